// ===== src/line_follow_obstacle_avoid_ctrl_core_macros.svh =====
// Assertion macros for the checker file.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef LINE_FOLLOW_OBSTACLE_AVOID_CTRL_CORE_MACROS_SVH
`define LINE_FOLLOW_OBSTACLE_AVOID_CTRL_CORE_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define LFOA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked while out of reset.
`define LFOA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/lfoa_pkg.sv =====
package lfoa_pkg;

	localparam int SENSOR_COUNT    = 5;
	localparam int SAMPLE_BITS_DEF = 12;

	localparam int THR_W      = 12;
	localparam int BASE_W     = 10;
	localparam int GAIN_W     = 9;
	localparam int SRCH_W     = 10;
	localparam int ECHO_W     = 15;
	localparam int MS_W       = 16;
	localparam int DT_W       = 8;
	localparam int DUTY_W     = 10;
	localparam int MODE_W     = 3;
	localparam int DUR_W      = 11;
	localparam int ACC_W      = 13;
	localparam int SUM_W      = 4;
	localparam int CNT_W      = 3;
	localparam int ERR_W      = 3;
	localparam int OUT_W      = 2 * DUTY_W + 1 + MODE_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [DUTY_W-1:0] DUTY_MAX = 10'd1000;
	localparam logic [MS_W-1:0]   FIND_MS  = 16'd1200;

	// register reset values
	localparam logic [THR_W-1:0]  THR_RST   = 12'd2662;
	localparam logic [BASE_W-1:0] BASE_RST  = 10'd150;
	localparam logic [GAIN_W-1:0] GAIN_RST  = 9'd75;
	localparam logic [SRCH_W-1:0] SRCH_RST  = 10'd100;
	localparam logic [ECHO_W-1:0] ECHO_RST  = 15'd1050;
	localparam logic [MS_W-1:0]   SMP_RST   = 16'd80;
	localparam logic [MS_W-1:0]   REARM_RST = 16'd2500;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WHITE_THRESHOLD     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED          = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TURN_GAIN           = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_SPEED        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OBSTACLE_ECHO_LIMIT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL_MS  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_REARM_DELAY_MS      = 3'd6;

	typedef enum logic [MODE_W-1:0] {
		MODE_FOLLOW     = 3'd0,
		MODE_STOP       = 3'd1,
		MODE_REVERSE    = 3'd2,
		MODE_TURN_RIGHT = 3'd3,
		MODE_PASS       = 3'd4,
		MODE_TURN_LEFT  = 3'd5,
		MODE_FIND       = 3'd6
	} mode_t;

	typedef struct packed {
		logic [THR_W-1:0]  thr;
		logic [BASE_W-1:0] base;
		logic [GAIN_W-1:0] gain;
		logic [SRCH_W-1:0] srch;
		logic [ECHO_W-1:0] echo_lim;
		logic [MS_W-1:0]   smp_ivl;
		logic [MS_W-1:0]   rearm;
	} cfg_t;

	// micro-operations of the datapath
	typedef enum logic [2:0] {
		UOP_TICK,
		UOP_DUTY,
		UOP_SAMPLE,
		UOP_FIND,
		UOP_FIXED,
		UOP_REPAIR,
		UOP_EMIT
	} uop_t;

	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_GOTO,
		JMP_MODE,
		JMP_END
	} jmp_t;

	localparam int UPC_W = 3;
	typedef logic [UPC_W-1:0] upc_t;

	localparam upc_t UA_TICK     = 3'd0;
	localparam upc_t UA_F_DUTY   = 3'd1;
	localparam upc_t UA_F_SAMPLE = 3'd2;
	localparam upc_t UA_S_DUTY   = 3'd3;
	localparam upc_t UA_S_FIND   = 3'd4;
	localparam upc_t UA_FIXED    = 3'd5;
	localparam upc_t UA_REPAIR   = 3'd6;
	localparam upc_t UA_EMIT     = 3'd7;

	typedef struct packed {
		uop_t uop;
		jmp_t jmp;
		upc_t target;
	} uword_t;

	typedef struct packed {
		logic act;
		uop_t uop;
	} ctl_t;

	typedef struct packed {
		mode_t mode;
		logic  stall;
	} stat_t;

	typedef struct packed {
		logic [DUTY_W-1:0] l;
		logic [DUTY_W-1:0] r;
		logic [DUR_W-1:0]  dur;
		mode_t             next;
	} fixed_t;

	function automatic uword_t ucode_rom(upc_t a);
		uword_t w;
		unique case (a)
			UA_TICK:     w = '{uop: UOP_TICK,   jmp: JMP_MODE, target: UA_TICK};
			UA_F_DUTY:   w = '{uop: UOP_DUTY,   jmp: JMP_NEXT, target: UA_TICK};
			UA_F_SAMPLE: w = '{uop: UOP_SAMPLE, jmp: JMP_GOTO, target: UA_EMIT};
			UA_S_DUTY:   w = '{uop: UOP_DUTY,   jmp: JMP_NEXT, target: UA_TICK};
			UA_S_FIND:   w = '{uop: UOP_FIND,   jmp: JMP_GOTO, target: UA_EMIT};
			UA_FIXED:    w = '{uop: UOP_FIXED,  jmp: JMP_GOTO, target: UA_EMIT};
			UA_REPAIR:   w = '{uop: UOP_REPAIR, jmp: JMP_GOTO, target: UA_EMIT};
			UA_EMIT:     w = '{uop: UOP_EMIT,   jmp: JMP_END,  target: UA_TICK};
			default:     w = '{uop: UOP_EMIT,   jmp: JMP_END,  target: UA_TICK};
		endcase
		return w;
	endfunction

	function automatic upc_t dispatch(mode_t m);
		upc_t a;
		unique case (m) inside
			MODE_FOLLOW: a = UA_F_DUTY;
			MODE_FIND:   a = UA_S_DUTY;
			MODE_STOP, MODE_REVERSE, MODE_TURN_RIGHT, MODE_PASS, MODE_TURN_LEFT:
				a = UA_FIXED;
			default:     a = UA_REPAIR;
		endcase
		return a;
	endfunction

	function automatic fixed_t fixed_step(mode_t m);
		fixed_t f;
		unique case (m)
			MODE_STOP:       f = '{l: 10'd0,   r: 10'd0,   dur: 11'd200, next: MODE_REVERSE};
			MODE_REVERSE:    f = '{l: 10'd100, r: 10'd100, dur: 11'd150, next: MODE_TURN_RIGHT};
			MODE_TURN_RIGHT: f = '{l: 10'd170, r: 10'd30,  dur: 11'd380, next: MODE_PASS};
			MODE_PASS:       f = '{l: 10'd140, r: 10'd140, dur: 11'd750, next: MODE_TURN_LEFT};
			MODE_TURN_LEFT:  f = '{l: 10'd30,  r: 10'd170, dur: 11'd380, next: MODE_FIND};
			default:         f = '{l: 10'd0,   r: 10'd0,   dur: 11'd0,   next: MODE_FOLLOW};
		endcase
		return f;
	endfunction

	// Truncating divide of a hit-position sum (|sum| <= 3) by the hit count (0..5; zero hits give zero).
	function automatic logic signed [ERR_W-1:0] pos_error(logic signed [SUM_W-1:0] sum,
			logic [CNT_W-1:0] cnt);
		logic [1:0] mag;
		logic [1:0] q;
		mag = sum[SUM_W-1] ? 2'(-sum) : sum[1:0];
		if (cnt == '0)
			q = 2'd0;
		else if (cnt == 3'd1)
			q = mag;
		else
			q = {1'b0, ({1'b0, mag} >= cnt)};
		return sum[SUM_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
	endfunction

	function automatic logic [DUTY_W-1:0] duty_clamp(logic signed [ACC_W-1:0] v);
		logic [DUTY_W-1:0] d;
		if (v < 0)
			d = '0;
		else if (v > $signed({{(ACC_W-DUTY_W){1'b0}}, DUTY_MAX}))
			d = DUTY_MAX;
		else
			d = v[DUTY_W-1:0];
		return d;
	endfunction

	function automatic logic [MS_W-1:0] sat_add(logic [MS_W-1:0] t, logic [DT_W-1:0] d);
		logic [MS_W:0] s;
		s = {1'b0, t} + (MS_W+1)'(d);
		return s[MS_W] ? '1 : s[MS_W-1:0];
	endfunction

endpackage

// ===== src/lfoa_useq.sv =====
module lfoa_useq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  lfoa_pkg::stat_t stat,
	output lfoa_pkg::ctl_t  ctl,
	output logic           busy
);
	import lfoa_pkg::*;

	upc_t   upc_q;
	logic   busy_q;
	uword_t word;

	assign word = ucode_rom(upc_q);
	assign ctl  = '{act: busy_q, uop: word.uop};
	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			upc_q  <= UA_TICK;
		end else if (!busy_q) begin
			if (start) begin
				busy_q <= 1'b1;
				upc_q  <= UA_TICK;
			end
		end else if (!(word.uop == UOP_EMIT && stat.stall)) begin
			unique case (word.jmp)
				JMP_NEXT: upc_q  <= upc_q + 1'b1;
				JMP_GOTO: upc_q  <= word.target;
				JMP_MODE: upc_q  <= dispatch(stat.mode);
				JMP_END:  busy_q <= 1'b0;
				default:  busy_q <= 1'b0;
			endcase
		end
	end

endmodule

// ===== src/lfoa_dpath.sv =====
module lfoa_dpath #(
	parameter int SAMPLE_BITS = lfoa_pkg::SAMPLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lfoa_pkg::cfg_t        cfg,
	input  logic                  load,
	input  logic [lfoa_pkg::SENSOR_COUNT*SAMPLE_BITS+lfoa_pkg::DT_W+lfoa_pkg::ECHO_W-1:0]
	                              in_data,
	input  logic                  echo_valid,
	input  lfoa_pkg::ctl_t        ctl,
	output lfoa_pkg::stat_t       stat,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [lfoa_pkg::OUT_W-1:0] out_data
);
	import lfoa_pkg::*;

	localparam int CMP_W    = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
	localparam int DT_OFF   = SENSOR_COUNT * SAMPLE_BITS;
	localparam int ECHO_OFF = DT_OFF + DT_W;

	// payload captured per item
	logic [SENSOR_COUNT-1:0]  hits_q;
	logic [DT_W-1:0]          dt_q;
	logic                     echo_hit_q;
	logic signed [ERR_W-1:0]  err_q;
	logic                     nohit_q;
	logic                     sign_q;
	logic [OUT_W-1:0]         out_data_q;

	// controller state
	logic [MS_W-1:0]   step_q;
	logic [MS_W-1:0]   smp_q;
	logic [MS_W-1:0]   rearm_q;
	mode_t             mode_q;
	logic              last_q;
	logic              fwd_q;
	logic [DUTY_W-1:0] lduty_q;
	logic [DUTY_W-1:0] rduty_q;
	logic              out_valid_q;

	logic [SENSOR_COUNT-1:0] hit_d;
	logic [ECHO_W-1:0]       echo_d;
	logic                    echo_hit_d;
	logic signed [SUM_W-1:0] sum_c;
	logic [CNT_W-1:0]        cnt_c;
	logic signed [ACC_W-1:0] prod_c;
	logic signed [ACC_W-1:0] lsum_c;
	logic signed [ACC_W-1:0] rsum_c;
	logic [DUTY_W-1:0]       srch_c;
	fixed_t                  fx;
	logic                    step_done;
	logic                    stall;

	always_comb begin
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			hit_d[i] = CMP_W'(in_data[i*SAMPLE_BITS +: SAMPLE_BITS]) >= CMP_W'(cfg.thr);
		end
	end

	assign echo_d     = in_data[ECHO_OFF +: ECHO_W];
	assign echo_hit_d = echo_valid && (echo_d != '0) && (echo_d < cfg.echo_lim);

	// positions +2, +1, 0, -1, -2 from right to left
	assign sum_c = $signed({2'b00, hits_q[0], 1'b0}) + $signed({3'b000, hits_q[1]})
		- $signed({3'b000, hits_q[3]}) - $signed({2'b00, hits_q[4], 1'b0});

	always_comb begin
		cnt_c = '0;
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			cnt_c = cnt_c + CNT_W'(hits_q[i]);
		end
	end

	assign prod_c = $signed({{(ACC_W-GAIN_W){1'b0}}, cfg.gain})
		* $signed({{(ACC_W-ERR_W){err_q[ERR_W-1]}}, err_q});
	assign lsum_c = $signed({{(ACC_W-BASE_W){1'b0}}, cfg.base}) + prod_c;
	assign rsum_c = $signed({{(ACC_W-BASE_W){1'b0}}, cfg.base}) - prod_c;
	assign srch_c = duty_clamp($signed({{(ACC_W-SRCH_W){1'b0}}, cfg.srch}));

	assign fx        = fixed_step(mode_q);
	assign step_done = step_q >= MS_W'(fx.dur);
	assign stall     = out_valid_q && !out_ready;

	assign stat      = '{mode: mode_q, stall: stall};
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk) begin
		if (load) begin
			hits_q     <= hit_d;
			dt_q       <= in_data[DT_OFF +: DT_W];
			echo_hit_q <= echo_hit_d;
		end
		if (ctl.act && ctl.uop == UOP_TICK) begin
			err_q   <= pos_error(sum_c, cnt_c);
			nohit_q <= (cnt_c == '0);
			sign_q  <= !sum_c[SUM_W-1];
		end
		if (ctl.act && ctl.uop == UOP_EMIT && !stall)
			out_data_q <= {mode_q, fwd_q, rduty_q, lduty_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			smp_q       <= '0;
			rearm_q     <= '0;
			mode_q      <= MODE_FOLLOW;
			last_q      <= 1'b1;
			fwd_q       <= 1'b1;
			lduty_q     <= '0;
			rduty_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load a new result, else drop the flag once the result is taken
			if (ctl.act && ctl.uop == UOP_EMIT && !stall)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (ctl.act) begin
				unique case (ctl.uop)
					UOP_TICK: begin
						step_q  <= sat_add(step_q, dt_q);
						smp_q   <= sat_add(smp_q, dt_q);
						rearm_q <= sat_add(rearm_q, dt_q);
					end
					UOP_DUTY: begin
						if (nohit_q) begin
							lduty_q <= last_q ? srch_c : '0;
							rduty_q <= last_q ? '0 : srch_c;
						end else begin
							lduty_q <= duty_clamp(lsum_c);
							rduty_q <= duty_clamp(rsum_c);
							last_q  <= sign_q;
						end
					end
					UOP_SAMPLE: begin
						if (smp_q >= cfg.smp_ivl) begin
							smp_q <= '0;
							if (rearm_q >= cfg.rearm && echo_hit_q) begin
								mode_q  <= MODE_STOP;
								step_q  <= '0;
								rearm_q <= '0;
							end
						end
					end
					UOP_FIND: begin
						if (step_q >= FIND_MS)
							mode_q <= MODE_FOLLOW;
					end
					UOP_FIXED: begin
						lduty_q <= fx.l;
						rduty_q <= fx.r;
						if (mode_q == MODE_REVERSE)
							fwd_q <= step_done;
						if (step_done) begin
							mode_q <= fx.next;
							step_q <= '0;
						end
					end
					UOP_REPAIR: mode_q <= MODE_FOLLOW;
					UOP_EMIT: ;
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== src/line_follow_obstacle_avoid_ctrl_core.sv =====
// Each accepted item runs a microprogram: tick, duty, sample check, emit in follow mode;
// tick, duty, find-line check, emit in find-line mode; tick, fixed step, emit in the
// avoidance steps. One microprogram step per cycle, but emit waits while the output stalls.
// A new item is accepted only once the microprogram of the previous item has ended.
// A finished result waits in the output register while the next item is taken.
// Reset: arst_n resets timers, mode, duties, steering memory and output flag, and restores register defaults at once.
module line_follow_obstacle_avoid_ctrl_core #(
	parameter int SAMPLE_BITS = lfoa_pkg::SAMPLE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,

	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// sensor_right, sensor_inner_right, sensor_center, sensor_inner_left, sensor_left,
	// elapsed_ms, echo_us, zero pad
	input  logic [((lfoa_pkg::SENSOR_COUNT*SAMPLE_BITS+lfoa_pkg::DT_W+lfoa_pkg::ECHO_W+7)/8)*8-1:0]
	             s_axis_tdata,
	input  logic s_axis_tuser,   // echo_valid

	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [lfoa_pkg::OUT_W-1:0] m_axis_tdata,   // left_duty, right_duty, drive_forward, mode

	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lfoa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lfoa_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lfoa_pkg::*;

	localparam int PACK_W = SENSOR_COUNT * SAMPLE_BITS + DT_W + ECHO_W;

	cfg_t  cfg_q;
	ctl_t  ctl;
	stat_t stat;
	logic  busy;
	logic  start;

	// One item in flight; config writes land any cycle, the caller keeps them to idle time.
	assign s_axis_tready = !busy;
	assign start         = s_axis_tvalid && !busy;
	assign cfg_ready     = 1'b1;

	// Register file: one transaction writes one register, unknown indexes drop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr      <= THR_RST;
			cfg_q.base     <= BASE_RST;
			cfg_q.gain     <= GAIN_RST;
			cfg_q.srch     <= SRCH_RST;
			cfg_q.echo_lim <= ECHO_RST;
			cfg_q.smp_ivl  <= SMP_RST;
			cfg_q.rearm    <= REARM_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WHITE_THRESHOLD:     cfg_q.thr      <= cfg_data[THR_W-1:0];
				CFG_BASE_SPEED:          cfg_q.base     <= cfg_data[BASE_W-1:0];
				CFG_TURN_GAIN:           cfg_q.gain     <= cfg_data[GAIN_W-1:0];
				CFG_SEARCH_SPEED:        cfg_q.srch     <= cfg_data[SRCH_W-1:0];
				CFG_OBSTACLE_ECHO_LIMIT: cfg_q.echo_lim <= cfg_data[ECHO_W-1:0];
				CFG_SAMPLE_INTERVAL_MS:  cfg_q.smp_ivl  <= cfg_data[MS_W-1:0];
				CFG_REARM_DELAY_MS:      cfg_q.rearm    <= cfg_data[MS_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer: step counter over the control-word table, dispatch on the current mode.
	lfoa_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy)
	);

	// Datapath: thresholds, error, duties, timers, mode, output register.
	lfoa_dpath #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.load       (start),
		.in_data    (s_axis_tdata[PACK_W-1:0]),
		.echo_valid (s_axis_tuser),
		.ctl        (ctl),
		.stat       (stat),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata)
	);

endmodule

// ===== src/lfoa_chk.sv =====
`include "line_follow_obstacle_avoid_ctrl_core_macros.svh"

module lfoa_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       m_axis_tvalid,
	input logic                       m_axis_tready,
	input logic [lfoa_pkg::OUT_W-1:0] m_axis_tdata
);
	import lfoa_pkg::*;

	logic [DUTY_W-1:0] left_f;
	logic [DUTY_W-1:0] right_f;
	logic              fwd_f;
	logic [MODE_W-1:0] mode_f;

	assign left_f  = m_axis_tdata[DUTY_W-1:0];
	assign right_f = m_axis_tdata[2*DUTY_W-1:DUTY_W];
	assign fwd_f   = m_axis_tdata[2*DUTY_W];
	assign mode_f  = m_axis_tdata[OUT_W-1:2*DUTY_W+1];

	// a stalled result holds
	`LFOA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
	// duties stay in 0..1000
	`LFOA_ASSERT_NOW(a_duty_range, m_axis_tvalid, left_f <= DUTY_MAX && right_f <= DUTY_MAX, "duty out of range")
	// reverse drive only while the reverse step is still running
	`LFOA_ASSERT_NOW(a_reverse_mode, m_axis_tvalid && !fwd_f, mode_f == MODE_REVERSE, "reverse drive outside reverse step")

endmodule

bind line_follow_obstacle_avoid_ctrl_core lfoa_chk u_lfoa_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== dv/line_follow_obstacle_avoid_ctrl_core_tb.sv =====
`timescale 1ns / 100ps

module line_follow_obstacle_avoid_ctrl_core_tb;
	import lfoa_pkg::*;

	// Pack the input transaction: five samples (right first), elapsed_ms, echo_us, zero pad.
	localparam int S_BITS    = SAMPLE_BITS_DEF;
	localparam int SENS_BITS = SENSOR_COUNT * S_BITS;
	localparam int DT_LSB    = SENS_BITS;
	localparam int ECHO_LSB  = DT_LSB + DT_W;
	localparam int IN_BITS   = ECHO_LSB + ECHO_W;
	localparam int TDATA_W   = ((IN_BITS + 7) / 8) * 8;
	localparam int S_MAX     = (1 << S_BITS) - 1;

	// Avoidance step lengths in ms and the fixed duties of each step.
	localparam int STOP_MS      = 200;
	localparam int REVERSE_MS   = 150;
	localparam int TURN_MS      = 380;
	localparam int PASS_MS      = 750;
	localparam int FIND_LINE_MS = 1200;
	localparam int REVERSE_DUTY = 100;
	localparam int TURN_FAST    = 170;
	localparam int TURN_SLOW    = 30;
	localparam int PASS_DUTY    = 140;
	localparam int DUTY_TOP     = 1000;
	localparam int TIMER_TOP    = 65535;
	localparam int ECHO_TOP     = 30000;

	// Index past the register file; the block must drop writes to it.
	localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

	localparam int DRAIN_CYCLES = 12;    // extra wait after the last predicted result
	localparam int STALL_LIMIT  = 5000;  // cycles with no transaction anywhere
	localparam int HOLD_CYCLES  = 300;   // long receiver back-pressure stretch
	localparam int HOLD_AFTER   = 400;   // results seen before the stretch starts
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic [SENSOR_COUNT-1:0][S_BITS-1:0] sens;  // [0] = right end, +2
		logic [DT_W-1:0]                     dt;
		logic                                echo_ok;
		logic [ECHO_W-1:0]                   echo_us;
	} ctrl_tick_t;

	typedef struct packed {
		logic [DUTY_W-1:0] l_duty;
		logic [DUTY_W-1:0] r_duty;
		logic              fwd;
		mode_t             mode;
	} motor_cmd_t;

	// Expected motor commands: an own model of the controller plus the queue of
	// commands it has predicted for ticks the block has accepted.
	class motor_cmd_scoreboard;
		cfg_t        regs;
		mode_t       mode;
		logic [15:0] step_ms, sample_ms, rearm_ms;
		bit          err_nonneg, fwd;
		int          held_l, held_r;
		motor_cmd_t  expected_cmds[$];
		int          errors, n_ticks, n_checked, n_avoid, n_search;

		function void reset_state();
			regs = '{thr: THR_RST, base: BASE_RST, gain: GAIN_RST, srch: SRCH_RST,
				echo_lim: ECHO_RST, smp_ivl: SMP_RST, rearm: REARM_RST};
			mode       = MODE_FOLLOW;
			step_ms    = '0;
			sample_ms  = '0;
			rearm_ms   = '0;
			err_nonneg = 1'b1;
			fwd        = 1'b1;
			held_l     = 0;
			held_r     = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_WHITE_THRESHOLD:     regs.thr      = val[THR_W-1:0];
				CFG_BASE_SPEED:          regs.base     = val[BASE_W-1:0];
				CFG_TURN_GAIN:           regs.gain     = val[GAIN_W-1:0];
				CFG_SEARCH_SPEED:        regs.srch     = val[SRCH_W-1:0];
				CFG_OBSTACLE_ECHO_LIMIT: regs.echo_lim = val[ECHO_W-1:0];
				CFG_SAMPLE_INTERVAL_MS:  regs.smp_ivl  = val[MS_W-1:0];
				CFG_REARM_DELAY_MS:      regs.rearm    = val[MS_W-1:0];
				default: ;
			endcase
		endfunction

		function int clamp_duty(int v);
			return (v < 0) ? 0 : (v > DUTY_TOP) ? DUTY_TOP : v;
		endfunction

		function logic [15:0] sat_ms(logic [15:0] t, logic [DT_W-1:0] d);
			int s;
			s = int'(t) + int'(d);
			return (s > TIMER_TOP) ? 16'(TIMER_TOP) : 16'(s);
		endfunction

		// Weighted hit position, truncated toward zero; search on one wheel when lost.
		function void steer(ctrl_tick_t t, output int l, output int r);
			int sum, cnt, err;
			sum = 0;
			cnt = 0;
			for (int i = 0; i < SENSOR_COUNT; i++) begin
				if (t.sens[i] >= regs.thr) begin
					sum += 2 - i;
					cnt++;
				end
			end
			if (cnt == 0) begin
				n_search++;
				l = err_nonneg ? clamp_duty(int'(regs.srch)) : 0;
				r = err_nonneg ? 0 : clamp_duty(int'(regs.srch));
			end else begin
				err        = sum / cnt;
				err_nonneg = (sum >= 0);
				l = clamp_duty(int'(regs.base) + int'(regs.gain) * err);
				r = clamp_duty(int'(regs.base) - int'(regs.gain) * err);
			end
		endfunction

		function void end_step(int dur, mode_t nxt);
			if (step_ms >= dur) begin
				mode    = nxt;
				step_ms = '0;
			end
		endfunction

		function void note_tick(ctrl_tick_t t);
			int l, r;
			motor_cmd_t c;
			l = held_l;
			r = held_r;
			step_ms   = sat_ms(step_ms, t.dt);
			sample_ms = sat_ms(sample_ms, t.dt);
			rearm_ms  = sat_ms(rearm_ms, t.dt);
			case (mode)
				MODE_FOLLOW: begin
					steer(t, l, r);
					if (sample_ms >= regs.smp_ivl) begin
						sample_ms = '0;
						if (rearm_ms >= regs.rearm && t.echo_ok && t.echo_us != 0 &&
								t.echo_us < regs.echo_lim) begin
							mode     = MODE_STOP;
							step_ms  = '0;
							rearm_ms = '0;
							n_avoid++;
						end
					end
				end
				MODE_STOP: begin
					l = 0;
					r = 0;
					end_step(STOP_MS, MODE_REVERSE);
				end
				MODE_REVERSE: begin
					// Back up; the tick that finishes the step already reports forward.
					l   = REVERSE_DUTY;
					r   = REVERSE_DUTY;
					fwd = (step_ms >= REVERSE_MS);
					end_step(REVERSE_MS, MODE_TURN_RIGHT);
				end
				MODE_TURN_RIGHT: begin
					l = TURN_FAST;
					r = TURN_SLOW;
					end_step(TURN_MS, MODE_PASS);
				end
				MODE_PASS: begin
					l = PASS_DUTY;
					r = PASS_DUTY;
					end_step(PASS_MS, MODE_TURN_LEFT);
				end
				MODE_TURN_LEFT: begin
					l = TURN_SLOW;
					r = TURN_FAST;
					end_step(TURN_MS, MODE_FIND);
				end
				MODE_FIND: begin
					steer(t, l, r);
					if (step_ms >= FIND_LINE_MS)
						mode = MODE_FOLLOW;
				end
				default: mode = MODE_FOLLOW;
			endcase
			held_l = l;
			held_r = r;
			c = '{l_duty: DUTY_W'(l), r_duty: DUTY_W'(r), fwd: fwd, mode: mode};
			expected_cmds.push_back(c);
			n_ticks++;
		endfunction

		function void report(string what, motor_cmd_t e, motor_cmd_t g);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: %s: expected L=%0d R=%0d fwd=%0d mode=%0d, got L=%0d R=%0d fwd=%0d mode=%0d",
					$time, what, e.l_duty, e.r_duty, e.fwd, e.mode,
					g.l_duty, g.r_duty, g.fwd, g.mode);
		endfunction

		function void check_cmd(motor_cmd_t got);
			motor_cmd_t e;
			if (expected_cmds.size() == 0) begin
				report("result with no tick pending", '0, got);
				return;
			end
			e = expected_cmds.pop_front();
			n_checked++;
			if (got.l_duty !== e.l_duty || got.r_duty !== e.r_duty ||
					got.fwd !== e.fwd || got.mode !== e.mode)
				report("command mismatch", e, got);
		endfunction

		function int pending();
			return expected_cmds.size();
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	logic [TDATA_W-1:0]              s_axis_tdata;
	logic                            s_axis_tuser;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready;
	logic [OUT_W-1:0]                m_axis_tdata;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [CFG_IDX_W-1:0]            cfg_index;
	logic [CFG_DATA_W-1:0]           cfg_data;

	motor_cmd_scoreboard sb;
	int tx_idle_pct;   // chance per cycle that the sender holds off
	int rx_idle_pct;   // chance per cycle that the receiver holds off
	int rx_count;
	int n_settings;
	int stall_cycles;
	bit rx_hold_done;

	line_follow_obstacle_avoid_ctrl_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [TDATA_W-1:0] pack_tick(ctrl_tick_t t);
		logic [TDATA_W-1:0] d;
		d = '0;
		d[SENS_BITS-1:0]            = t.sens;
		d[DT_LSB +: DT_W]           = t.dt;
		d[ECHO_LSB +: ECHO_W]       = t.echo_us;
		return d;
	endfunction

	function automatic ctrl_tick_t unpack_tick(logic [TDATA_W-1:0] d, logic user);
		ctrl_tick_t t;
		t.sens    = d[SENS_BITS-1:0];
		t.dt      = d[DT_LSB +: DT_W];
		t.echo_us = d[ECHO_LSB +: ECHO_W];
		t.echo_ok = user;
		return t;
	endfunction

	function automatic motor_cmd_t unpack_cmd(logic [OUT_W-1:0] d);
		motor_cmd_t c;
		c.l_duty = d[DUTY_W-1:0];
		c.r_duty = d[DUTY_W +: DUTY_W];
		c.fwd    = d[2*DUTY_W];
		c.mode   = mode_t'(d[2*DUTY_W+1 +: MODE_W]);
		return c;
	endfunction

	// Build one directed tick; samples given right end first.
	function automatic ctrl_tick_t mk_tick(int s_r, int s_ir, int s_c, int s_il, int s_l,
			int dt, bit ok, int echo);
		ctrl_tick_t t;
		t.sens    = {S_BITS'(s_l), S_BITS'(s_il), S_BITS'(s_c), S_BITS'(s_ir), S_BITS'(s_r)};
		t.dt      = DT_W'(dt);
		t.echo_ok = ok;
		t.echo_us = ECHO_W'(echo);
		return t;
	endfunction

	// Random tick. Most ticks carry a clean hit pattern against the current
	// threshold and a fair share of close echoes, so avoidance runs start often;
	// the rest is raw noise. With long_gaps every tick advances the timers a lot,
	// which drives them into saturation.
	function automatic ctrl_tick_t rand_tick(bit long_gaps);
		ctrl_tick_t t;
		int thr, lim, hits, pick;
		thr  = int'(sb.regs.thr);
		lim  = int'(sb.regs.echo_lim);
		pick = $urandom_range(0, 99);
		hits = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 31);
		for (int i = 0; i < SENSOR_COUNT; i++) begin
			if (pick < 20 || thr == 0)
				t.sens[i] = S_BITS'($urandom_range(0, S_MAX));
			else if (hits[i])
				t.sens[i] = S_BITS'($urandom_range(thr, S_MAX));
			else
				t.sens[i] = S_BITS'($urandom_range(0, thr - 1));
		end
		pick = $urandom_range(0, 99);
		if (long_gaps)
			t.dt = DT_W'($urandom_range(200, 255));
		else if (pick < 45)
			t.dt = DT_W'($urandom_range(0, 40));
		else if (pick < 90)
			t.dt = DT_W'($urandom_range(0, 255));
		else if (pick < 95)
			t.dt = '1;
		else
			t.dt = '0;
		pick = $urandom_range(0, 99);
		if (pick < 30 && lim > 1) begin
			t.echo_ok = 1'b1;
			t.echo_us = ECHO_W'($urandom_range(1, lim - 1));
		end else if (pick < 38) begin
			t.echo_ok = 1'($urandom_range(0, 1));
			t.echo_us = ECHO_W'(lim);
		end else if (pick < 43) begin
			t.echo_ok = 1'($urandom_range(0, 1));
			t.echo_us = '0;
		end else begin
			t.echo_ok = 1'($urandom_range(0, 1));
			t.echo_us = ECHO_W'($urandom_range(0, ECHO_TOP));
		end
		return t;
	endfunction

	// Offer one tick; idle at random first, then hold it until it is taken.
	task automatic send_tick(input ctrl_tick_t t);
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pack_tick(t);
		s_axis_tuser  <= t.echo_ok;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Drop valid and wait until every predicted command has come back.
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
	endtask

	task automatic apply_settings(input int thr, input int base, input int gain, input int srch,
			input int lim, input int smp, input int rearm);
		cfg_write(CFG_WHITE_THRESHOLD, CFG_DATA_W'(thr));
		cfg_write(CFG_BASE_SPEED, CFG_DATA_W'(base));
		cfg_write(CFG_TURN_GAIN, CFG_DATA_W'(gain));
		cfg_write(CFG_SEARCH_SPEED, CFG_DATA_W'(srch));
		cfg_write(CFG_OBSTACLE_ECHO_LIMIT, CFG_DATA_W'(lim));
		cfg_write(CFG_SAMPLE_INTERVAL_MS, CFG_DATA_W'(smp));
		cfg_write(CFG_REARM_DELAY_MS, CFG_DATA_W'(rearm));
		@(negedge clk);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	task automatic run_phase(input int n, input bit long_gaps);
		for (int i = 0; i < n; i++)
			send_tick(rand_tick(long_gaps));
		drain();
	endtask

	// Receiver: random back-pressure, plus one long hold-off once enough results
	// have passed, so the block backs up and stalls its input.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (!rx_hold_done && rx_count >= HOLD_AFTER) begin
				rx_hold_done = 1'b1;
				m_axis_tready <= 1'b0;
				for (int k = 0; k < HOLD_CYCLES; k++)
					@(negedge clk);
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	// Monitor and watchdog: sample every transaction at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_tick(unpack_tick(s_axis_tdata, s_axis_tuser));
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_cmd(unpack_cmd(m_axis_tdata));
				rx_count++;
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d commands outstanding",
					$time, STALL_LIMIT, sb.pending());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = CFG_WHITE_THRESHOLD;
		cfg_data      = '0;
		tx_idle_pct   = 33;
		rx_idle_pct   = 50;
		rx_count      = 0;
		n_settings    = 1;
		stall_cycles  = 0;
		rx_hold_done  = 1'b0;
		sb = new;
		sb.reset_state();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// Directed ticks on reset settings: lost line with both search sides, every
		// kind of hit average, threshold edges, zero and invalid echo, an echo equal
		// to the limit, then one full avoidance run with the reverse step spread over
		// two ticks.
		send_tick(mk_tick(0, 0, 0, 0, 0, 0, 0, 0));
		send_tick(mk_tick(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 255, 1, 0));
		send_tick(mk_tick(0, 0, 0, 0, S_MAX, 255, 1, ECHO_TOP));
		send_tick(mk_tick(0, 0, 0, 0, 0, 255, 0, 1));
		send_tick(mk_tick(S_MAX, 0, 0, 0, 0, 255, 0, 0));
		send_tick(mk_tick(S_MAX, S_MAX, 0, 0, 0, 255, 0, 0));
		send_tick(mk_tick(2661, 2661, 2662, 2662, 2662, 255, 0, 0));
		send_tick(mk_tick(S_MAX, 0, 0, S_MAX, 0, 255, 0, 0));
		send_tick(mk_tick(0, 0, S_MAX, 0, 0, 255, 1, 1050));
		send_tick(mk_tick(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 255, 1, 0));
		send_tick(mk_tick(0, S_MAX, 0, 0, 0, 255, 0, 5));
		send_tick(mk_tick(0, 0, S_MAX, 0, 0, 80, 1, 1049));
		send_tick(mk_tick(0, 0, 0, 0, 0, 199, 1, 1));
		send_tick(mk_tick(0, 0, 0, 0, 0, 1, 1, 1));
		send_tick(mk_tick(0, 0, 0, 0, 0, 100, 1, 1));
		send_tick(mk_tick(0, 0, 0, 0, 0, 50, 1, 1));
		send_tick(mk_tick(0, 0, 0, 0, 0, 255, 1, 1));
		send_tick(mk_tick(0, 0, 0, 0, 0, 125, 1, 1));
		send_tick(mk_tick(0, 0, 0, 0, 0, 255, 1, 1));
		send_tick(mk_tick(0, 0, 0, 0, 0, 255, 1, 1));
		send_tick(mk_tick(0, 0, 0, 0, 0, 255, 1, 1));
		send_tick(mk_tick(0, 0, 0, 0, 0, 255, 1, 1));
		send_tick(mk_tick(0, 0, 0, 0, 0, 255, 1, 1));
		send_tick(mk_tick(0, 0, 0, 0, S_MAX, 255, 1, 1));
		drain();

		// Sender idles a third of the time, receiver half.
		apply_settings(0, 0, 500, 0, ECHO_TOP, 1, 0);
		run_phase(300, 1'b0);
		// Obstacles never qualify here; long ticks push every timer into saturation.
		apply_settings(S_MAX, 1000, 0, 1000, 1, TIMER_TOP, TIMER_TOP);
		run_phase(330, 1'b1);

		// Receiver idles a third of the time, sender half.
		tx_idle_pct = 50;
		rx_idle_pct = 33;
		// Speeds past 1000 must clamp; a zero interval checks the echo every tick.
		apply_settings(2000, 1023, 500, 1023, 2000, 0, 300);
		run_phase(350, 1'b0);
		apply_settings(1, 500, 1, 500, 15000, 40, 1000);
		run_phase(350, 1'b0);

		// No idling on either side.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		apply_settings($urandom_range(0, S_MAX), $urandom_range(0, 1000), $urandom_range(0, 500),
			$urandom_range(0, 1000), $urandom_range(1, ECHO_TOP), $urandom_range(1, 400),
			$urandom_range(0, 3000));
		run_phase(350, 1'b0);
		// A write past the register file must leave every setting alone.
		cfg_write(CFG_NO_REG, '1);
		apply_settings(int'(THR_RST), int'(BASE_RST), int'(GAIN_RST), int'(SRCH_RST),
			int'(ECHO_RST), int'(SMP_RST), int'(REARM_RST));
		run_phase(300, 1'b0);

		$display("Covered %0d control ticks (%0d commands checked) over %0d register settings",
			sb.n_ticks, sb.n_checked, n_settings);
		$display("Avoidance runs started: %0d, lost-line search ticks: %0d, mismatches: %0d",
			sb.n_avoid, sb.n_search, sb.errors);
		if (sb.pending() != 0)
			$display("%0d predicted commands never arrived", sb.pending());
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== line_follow_obstacle_avoid_ctrl_core.f =====
+incdir+src
src/lfoa_pkg.sv
src/lfoa_useq.sv
src/lfoa_dpath.sv
src/line_follow_obstacle_avoid_ctrl_core.sv
src/lfoa_chk.sv
dv/line_follow_obstacle_avoid_ctrl_core_tb.sv
